### hdl/etn_pkg.sv
package etn_pkg;

    localparam int X_W        = 21;
    localparam int AX_W       = 20;
    localparam int MAG_W      = 42;
    localparam int PROD_W     = MAG_W + AX_W;
    localparam int FRAC_SHIFT = 16;
    localparam int DIVD_W     = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 7;
    localparam int EPS_W      = 33;
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
    localparam int PC_W       = 4;

    localparam int MAX_TERMS = 64;

    localparam logic [EPS_W-1:0]      EPS_RESET = EPS_W'(4295);
    localparam logic [MAG_W-1:0]      ONE_Q32   = MAG_W'(1) << 32;
    localparam logic signed [X_W-1:0] X_LIMIT   = X_W'(524288);

    // Microprogram entry points.
    localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] STEP_CHECK    = 4'd1;
    localparam logic [PC_W-1:0] STEP_LIMCHK   = 4'd2;
    localparam logic [PC_W-1:0] STEP_ACCUM    = 4'd3;
    localparam logic [PC_W-1:0] STEP_DIVINIT  = 4'd4;
    localparam logic [PC_W-1:0] STEP_DIVLOOP  = 4'd5;
    localparam logic [PC_W-1:0] STEP_DIVDONE  = 4'd6;
    localparam logic [PC_W-1:0] STEP_SETLIMIT = 4'd7;
    localparam logic [PC_W-1:0] STEP_EMIT     = 4'd8;
    localparam logic [PC_W-1:0] STEP_RETURN   = 4'd9;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACCUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_SET_LIMIT,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_MAG_LE_EPS,
        C_LIMIT,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        logic in_valid;
        logic mag_le_eps;
        logic limit_reached;
        logic div_last;
        logic out_busy;
    } t_status;

endpackage

### hdl/etn_ucode_rom.sv
module etn_ucode_rom (
    input  logic [etn_pkg::PC_W-1:0] i_pc,
    output etn_pkg::t_ucode          o_ucode
);

    always_comb begin
        case (i_pc)
            etn_pkg::STEP_IDLE:
                o_ucode = '{etn_pkg::OP_LOAD, etn_pkg::C_NO_IN, etn_pkg::STEP_IDLE};
            etn_pkg::STEP_CHECK:
                o_ucode = '{etn_pkg::OP_NONE, etn_pkg::C_MAG_LE_EPS, etn_pkg::STEP_EMIT};
            etn_pkg::STEP_LIMCHK:
                o_ucode = '{etn_pkg::OP_NONE, etn_pkg::C_LIMIT, etn_pkg::STEP_SETLIMIT};
            etn_pkg::STEP_ACCUM:
                o_ucode = '{etn_pkg::OP_ACCUM, etn_pkg::C_NEVER, etn_pkg::STEP_IDLE};
            etn_pkg::STEP_DIVINIT:
                o_ucode = '{etn_pkg::OP_DIV_INIT, etn_pkg::C_NEVER, etn_pkg::STEP_IDLE};
            etn_pkg::STEP_DIVLOOP:
                o_ucode = '{etn_pkg::OP_DIV_STEP, etn_pkg::C_DIV_MORE, etn_pkg::STEP_DIVLOOP};
            etn_pkg::STEP_DIVDONE:
                o_ucode = '{etn_pkg::OP_DIV_DONE, etn_pkg::C_ALWAYS, etn_pkg::STEP_CHECK};
            etn_pkg::STEP_SETLIMIT:
                o_ucode = '{etn_pkg::OP_SET_LIMIT, etn_pkg::C_NEVER, etn_pkg::STEP_IDLE};
            etn_pkg::STEP_EMIT:
                o_ucode = '{etn_pkg::OP_EMIT, etn_pkg::C_OUT_BUSY, etn_pkg::STEP_EMIT};
            etn_pkg::STEP_RETURN:
                o_ucode = '{etn_pkg::OP_NONE, etn_pkg::C_ALWAYS, etn_pkg::STEP_IDLE};
            default:
                o_ucode = '{etn_pkg::OP_NONE, etn_pkg::C_ALWAYS, etn_pkg::STEP_IDLE};
        endcase
    end

endmodule

### hdl/etn_div.sv
module etn_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_step,
    input  logic [etn_pkg::DIVD_W-1:0]     i_dividend,
    input  logic [etn_pkg::CNT_W-1:0]      i_divisor,
    output logic [etn_pkg::DIVD_W-1:0]     o_quotient,
    output logic                           o_last
);

    logic [etn_pkg::CNT_W-1:0]     r_rem;
    logic [etn_pkg::DIVD_W-1:0]    r_quo;
    logic [etn_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [etn_pkg::CNT_W:0]       c_trial;
    logic [etn_pkg::CNT_W:0]       c_diff;
    logic                          c_ge;

    // Restoring division: the dividend shifts out of the top of r_quo while
    // quotient bits shift in at the bottom, one bit per cycle.
    always_comb begin
        c_trial = {r_rem, r_quo[etn_pkg::DIVD_W-1]};
        c_ge    = c_trial >= {1'b0, i_divisor};
        c_diff  = c_trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= etn_pkg::DIV_CNT_W'(etn_pkg::DIVD_W);
        end else if (i_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (i_step) begin
            r_rem <= c_ge ? c_diff[etn_pkg::CNT_W-1:0] : c_trial[etn_pkg::CNT_W-1:0];
            r_quo <= {r_quo[etn_pkg::DIVD_W-2:0], c_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_last     = r_cnt == etn_pkg::DIV_CNT_W'(1);

endmodule

### hdl/etn_datapath.sv
module etn_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  etn_pkg::t_op                      i_op,
    input  logic                              i_in_valid,
    input  logic signed [etn_pkg::X_W-1:0]    i_x_value,
    input  logic                              i_cfg_we,
    input  logic [etn_pkg::EPS_W-1:0]         i_cfg_wdata,
    input  logic                              i_out_stall,
    output etn_pkg::t_status                  o_status,
    output logic                              o_out_valid,
    output logic signed [etn_pkg::SUM_W-1:0]  o_sum_value,
    output logic [etn_pkg::CNT_W-1:0]         o_term_count,
    output logic                              o_limit_hit
);

    logic [etn_pkg::EPS_W-1:0]        r_eps;
    logic [etn_pkg::AX_W-1:0]         r_ax;
    logic                             r_x_pos;
    logic [etn_pkg::MAG_W-1:0]        r_mag;
    logic                             r_neg;
    logic signed [etn_pkg::SUM_W-1:0] r_sum;
    logic [etn_pkg::CNT_W-1:0]        r_n;
    logic [etn_pkg::PROD_W-1:0]       r_prod;
    logic                             r_limit;
    logic                             r_out_valid;
    logic signed [etn_pkg::SUM_W-1:0] r_out_sum;
    logic [etn_pkg::CNT_W-1:0]        r_out_cnt;
    logic                             r_out_lim;

    logic signed [etn_pkg::X_W-1:0]   c_x;
    logic [etn_pkg::X_W-1:0]          c_ax;
    logic signed [etn_pkg::SUM_W-1:0] c_mag_ext;
    logic                             c_load;
    logic                             c_emit;
    logic                             c_out_busy;
    logic [etn_pkg::DIVD_W-1:0]       w_quotient;
    logic                             w_div_last;

    etn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_op == etn_pkg::OP_DIV_INIT),
        .i_step     (i_op == etn_pkg::OP_DIV_STEP),
        .i_dividend (r_prod[etn_pkg::PROD_W-1:etn_pkg::FRAC_SHIFT]),
        .i_divisor  (r_n),
        .o_quotient (w_quotient),
        .o_last     (w_div_last)
    );

    always_comb begin
        if (i_x_value > etn_pkg::X_LIMIT) begin
            c_x = etn_pkg::X_LIMIT;
        end else if (i_x_value < -etn_pkg::X_LIMIT) begin
            c_x = -etn_pkg::X_LIMIT;
        end else begin
            c_x = i_x_value;
        end
        c_ax       = (c_x < 0) ? -c_x : c_x;
        c_mag_ext  = {{(etn_pkg::SUM_W - etn_pkg::MAG_W){1'b0}}, r_mag};
        c_out_busy = r_out_valid && i_out_stall;
        c_load     = (i_op == etn_pkg::OP_LOAD) && i_in_valid;
        c_emit     = (i_op == etn_pkg::OP_EMIT) && !c_out_busy;
    end

    always_comb begin
        o_status.in_valid      = i_in_valid;
        o_status.mag_le_eps    = r_mag <= {{(etn_pkg::MAG_W - etn_pkg::EPS_W){1'b0}}, r_eps};
        o_status.limit_reached = r_n >= etn_pkg::CNT_W'(etn_pkg::MAX_TERMS);
        o_status.div_last      = w_div_last;
        o_status.out_busy      = c_out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= etn_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_ax    <= c_ax[etn_pkg::AX_W-1:0];
            r_x_pos <= c_x > 0;
            r_mag   <= etn_pkg::ONE_Q32;
            r_neg   <= 1'b0;
            r_sum   <= '0;
            r_n     <= '0;
            r_limit <= 1'b0;
        end else begin
            case (i_op)
                etn_pkg::OP_ACCUM: begin
                    r_sum  <= r_neg ? r_sum - c_mag_ext : r_sum + c_mag_ext;
                    r_n    <= r_n + 1'b1;
                    r_prod <= r_mag * r_ax;
                    r_neg  <= r_neg != r_x_pos;
                end
                etn_pkg::OP_DIV_DONE: begin
                    r_mag <= w_quotient[etn_pkg::MAG_W-1:0];
                    // A term that truncates to zero counts as positive.
                    if (w_quotient == '0) begin
                        r_neg <= 1'b0;
                    end
                end
                etn_pkg::OP_SET_LIMIT: begin
                    r_limit <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_out_sum <= r_sum;
            r_out_cnt <= r_n;
            r_out_lim <= r_limit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sum_value  = r_out_sum;
    assign o_term_count = r_out_cnt;
    assign o_limit_hit  = r_out_lim;

endmodule

### hdl/etn_seq.sv
module etn_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  etn_pkg::t_ucode           i_ucode,
    input  etn_pkg::t_status          i_status,
    output logic [etn_pkg::PC_W-1:0]  o_pc
);

    logic [etn_pkg::PC_W-1:0] r_pc;
    logic [etn_pkg::PC_W-1:0] n_pc;
    logic                     c_jump;

    always_comb begin
        case (i_ucode.cond)
            etn_pkg::C_NEVER:      c_jump = 1'b0;
            etn_pkg::C_ALWAYS:     c_jump = 1'b1;
            etn_pkg::C_NO_IN:      c_jump = !i_status.in_valid;
            etn_pkg::C_MAG_LE_EPS: c_jump = i_status.mag_le_eps;
            etn_pkg::C_LIMIT:      c_jump = i_status.limit_reached;
            etn_pkg::C_DIV_MORE:   c_jump = !i_status.div_last;
            etn_pkg::C_OUT_BUSY:   c_jump = i_status.out_busy;
            default:               c_jump = 1'b1;
        endcase
        n_pc = c_jump ? i_ucode.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= etn_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_pc = r_pc;

endmodule

### hdl/exp_neg_taylor_series_core.sv
// Evaluates e^(-x) by its Taylor series for a signed Q4.16 argument, saturated
// to -8..8, and returns the Q16.32 sum, the number of terms added and a flag
// set when 64 terms were added while the next term still exceeded epsilon.
// Epsilon is a 33-bit Q1.32 threshold (reset 4295, about 1e-6); write it only
// while the block is idle. One word is taken at a time: the input is stalled
// from acceptance until the sequencer is back at its idle step, after the
// emit step has moved the result into the output register and the return
// step has run. Each term passes through the check, limit check, accumulate,
// divider start, divider loop and divider done steps; the divider produces
// one quotient bit per cycle over a 46-bit dividend. When the term limit ends
// the loop, a set-limit step comes before the emit step. A result still
// stalled in the output register holds the following word at its emit step.
module exp_neg_taylor_series_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [etn_pkg::X_W-1:0]    i_x_value,
    input  logic                              i_cfg_we,
    input  logic [etn_pkg::EPS_W-1:0]         i_cfg_wdata,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [etn_pkg::SUM_W-1:0]  o_sum_value,
    output logic [etn_pkg::CNT_W-1:0]         o_term_count,
    output logic                              o_limit_hit
);

    logic [etn_pkg::PC_W-1:0] w_pc;
    etn_pkg::t_ucode          w_ucode;
    etn_pkg::t_status         w_status;

    etn_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ucode  (w_ucode),
        .i_status (w_status),
        .o_pc     (w_pc)
    );

    etn_ucode_rom u_rom (
        .i_pc    (w_pc),
        .o_ucode (w_ucode)
    );

    etn_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_ucode.op),
        .i_in_valid   (i_in_valid),
        .i_x_value    (i_x_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_stall  (i_out_stall),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .o_sum_value  (o_sum_value),
        .o_term_count (o_term_count),
        .o_limit_hit  (o_limit_hit)
    );

    assign o_in_stall = w_pc != etn_pkg::STEP_IDLE;

    // An accepted word always starts the program.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> w_pc == etn_pkg::STEP_CHECK)
        else $error("accepted word did not start the term loop");

    // The limit flag only comes with a full term count.
    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_limit_hit |->
            o_term_count == etn_pkg::CNT_W'(etn_pkg::MAX_TERMS))
        else $error("limit flag with a short term count");

    // With no term added the sum must still be zero.
    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_limit_hit && o_term_count == '0 |-> o_sum_value == '0)
        else $error("nonzero sum with no terms added");

endmodule
